FILE: rtl/jcm_pkg.sv
// ----------------------------------------------------------------------------
// jcm_pkg
// Shared types and constants for the jet colour map pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package jcm_pkg;

  localparam int DATA_W    = 32;
  localparam int CPS_W     = 9;
  localparam int CPS_MAX   = 511;
  localparam int COLOR_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COLORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 2'd2;

  localparam logic [CPS_W-1:0]  CPS_RESET   = 9'd20;
  localparam logic [DATA_W-1:0] LOWER_RESET = 32'h0000_0000;
  localparam logic [DATA_W-1:0] UPPER_RESET = 32'h0001_0000;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_HALF = 8'd128;

  typedef enum logic [2:0] {
    SEG_DEEP_BLUE,
    SEG_GREEN_UP,
    SEG_CYAN_YELLOW,
    SEG_RED_HOLD,
    SEG_RED_FADE
  } seg_t;

  typedef struct packed {
    logic hit;
    seg_t seg;
  } tag_t;

endpackage

`default_nettype wire

FILE: rtl/jcm_div_pipe.sv
// ----------------------------------------------------------------------------
// jcm_div_pipe
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module jcm_div_pipe #(
  parameter int DW    = 43,
  parameter int VW    = 32,
  parameter int QW    = 11,
  parameter int LANES = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  jcm_pkg::tag_t                in_tag,
  input  logic [LANES-1:0][DW-1:0]     dividend,
  input  logic [VW-1:0]                divisor,
  output logic                         out_valid,
  output jcm_pkg::tag_t                out_tag,
  output logic [LANES-1:0][QW-1:0]     quotient
);
  import jcm_pkg::*;

  localparam int CW = VW + QW;

  logic [CW-1:0]                step     [QW];
  logic [LANES-1:0][CW-1:0]     rem_in   [QW];
  logic [LANES-1:0][CW-1:0]     rem_next [QW];
  logic [LANES-1:0][CW-1:0]     rem_q    [QW];
  logic [LANES-1:0][QW-1:0]     quo_in   [QW];
  logic [LANES-1:0][QW-1:0]     quo_next [QW];
  logic [LANES-1:0][QW-1:0]     quo_q    [QW];
  logic                         vld_q    [QW];
  tag_t                         tag_q    [QW];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_in[0][l] = CW'(dividend[l]);
    end
    quo_in[0] = '0;
    for (int s = 1; s < QW; s++) begin
      rem_in[s] = rem_q[s-1];
      quo_in[s] = quo_q[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      step[s] = CW'(divisor) << (QW - 1 - s);
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[s][l] >= step[s]) begin
          rem_next[s][l] = rem_in[s][l] - step[s];
          quo_next[s][l] = quo_in[s][l] | (QW'(1) << (QW - 1 - s));
        end else begin
          rem_next[s][l] = rem_in[s][l];
          quo_next[s][l] = quo_in[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= in_valid;
      for (int s = 1; s < QW; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_q[0] <= in_tag;
    for (int s = 1; s < QW; s++) begin
      tag_q[s] <= tag_q[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      rem_q[s] <= rem_next[s];
      quo_q[s] <= quo_next[s];
    end
  end

  assign out_valid = vld_q[QW-1];
  assign out_tag   = tag_q[QW-1];
  assign quotient  = quo_q[QW-1];

endmodule

`default_nettype wire

FILE: rtl/jcm_front.sv
// ----------------------------------------------------------------------------
// jcm_front
// Range test and scaled offset: (sample - lower) * total over two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module jcm_front #(
  parameter int TOT_W = 11
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [jcm_pkg::DATA_W-1:0]     sample,
  input  logic signed [jcm_pkg::DATA_W-1:0]     lower,
  input  logic signed [jcm_pkg::DATA_W-1:0]     upper,
  input  logic [TOT_W-1:0]                      total,
  output logic                                  out_valid,
  output jcm_pkg::tag_t                         out_tag,
  output logic [jcm_pkg::DATA_W+TOT_W-1:0]      product
);
  import jcm_pkg::*;

  localparam int PROD_W = DATA_W + TOT_W;

  logic              valid1;
  logic              hit1;
  logic [DATA_W-1:0] off1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1    <= in_valid;
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    hit1 <= (upper > lower) && (sample >= lower) && (sample <= upper);
    off1 <= DATA_W'(sample - lower);
    out_tag.hit <= hit1;
    out_tag.seg <= SEG_DEEP_BLUE;
    product <= hit1 ? PROD_W'(off1) * PROD_W'(total) : '0;
  end

endmodule

`default_nettype wire

FILE: rtl/jcm_segment.sv
// ----------------------------------------------------------------------------
// jcm_segment
// Splits the colour index into segment and position, forms shade dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module jcm_segment #(
  parameter int N_W   = 9,
  parameter int TOT_W = 11
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  input  jcm_pkg::tag_t                             in_tag,
  input  logic [TOT_W-1:0]                          idx,
  input  logic [N_W-1:0]                            n,
  input  logic [TOT_W-1:0]                          n2,
  input  logic [TOT_W-1:0]                          n3,
  input  logic [TOT_W-1:0]                          n4,
  input  logic [TOT_W-1:0]                          total,
  output logic                                      out_valid,
  output jcm_pkg::tag_t                             out_tag,
  output logic [1:0][N_W+jcm_pkg::COLOR_W-1:0]      dividend
);
  import jcm_pkg::*;

  localparam int SH_W = N_W + COLOR_W;

  seg_t             seg_c;
  logic [TOT_W-1:0] base_c;
  logic [TOT_W-1:0] diff_c;
  logic [N_W-1:0]   pos_c;

  logic             valid_a;
  tag_t             tag_a;
  logic [N_W-1:0]   pos_a;

  always_comb begin
    if (idx >= n4) begin
      seg_c  = SEG_RED_FADE;
      base_c = n4;
    end else if (idx >= n3) begin
      seg_c  = SEG_RED_HOLD;
      base_c = n3;
    end else if (idx >= n2) begin
      seg_c  = SEG_CYAN_YELLOW;
      base_c = n2;
    end else if (idx >= TOT_W'(n)) begin
      seg_c  = SEG_GREEN_UP;
      base_c = TOT_W'(n);
    end else begin
      seg_c  = SEG_DEEP_BLUE;
      base_c = '0;
    end
    diff_c = idx - base_c;
    // index at the upper bound clamps to the last step
    if (idx >= total) begin
      pos_c = n - N_W'(1);
    end else begin
      pos_c = N_W'(diff_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    tag_a.hit   <= in_tag.hit;
    tag_a.seg   <= seg_c;
    pos_a       <= pos_c;
    out_tag     <= tag_a;
    dividend[0] <= SH_W'(pos_a) * SH_W'(COLOR_FULL);
    dividend[1] <= SH_W'(pos_a) * SH_W'(COLOR_HALF);
  end

endmodule

`default_nettype wire

FILE: rtl/jcm_shade.sv
// ----------------------------------------------------------------------------
// jcm_shade
// Forms the output colour from segment and ramp values; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jcm_shade (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  jcm_pkg::tag_t                 in_tag,
  input  logic [jcm_pkg::COLOR_W-1:0]   ramp_full,
  input  logic [jcm_pkg::COLOR_W-1:0]   ramp_half,
  output logic                          strobe,
  output logic [jcm_pkg::COLOR_W-1:0]   red,
  output logic [jcm_pkg::COLOR_W-1:0]   green,
  output logic [jcm_pkg::COLOR_W-1:0]   blue,
  output logic                          hit
);
  import jcm_pkg::*;

  logic [COLOR_W-1:0] red_next;
  logic [COLOR_W-1:0] green_next;
  logic [COLOR_W-1:0] blue_next;

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    if (in_tag.hit) begin
      case (in_tag.seg)
        SEG_DEEP_BLUE: begin
          blue_next = COLOR_HALF + ramp_half;
        end
        SEG_GREEN_UP: begin
          green_next = ramp_full;
          blue_next  = COLOR_FULL;
        end
        SEG_CYAN_YELLOW: begin
          red_next   = ramp_full;
          green_next = COLOR_FULL;
          blue_next  = COLOR_FULL - ramp_full;
        end
        SEG_RED_HOLD: begin
          red_next   = COLOR_FULL;
          green_next = COLOR_FULL - ramp_full;
        end
        default: begin
          red_next = COLOR_FULL - ramp_half;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
    hit   <= in_tag.hit;
  end

endmodule

`default_nettype wire

FILE: rtl/jet_colormap_lookup.sv
// path: an accepted sample passes the front stages, the index divider, the segment
//   stages, the ramp divider and the shade output register before strobe
// throughput: one sample per cycle, busy stays low; the index divider adds
//   one stage per quotient bit, the shade divider eight
// results cannot be stalled, every accepted sample gives one strobe
// rst (synchronous) empties the pipeline and loads the register defaults
// ----------------------------------------------------------------------------
// jet_colormap_lookup
// Maps a signed Q16.16 sample to a five-segment jet colour, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_colormap_lookup #(
  parameter int MAX_STEPS_PER_SEGMENT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [jcm_pkg::DATA_W-1:0]   sample,
  output logic                                busy,
  output logic                                strobe,
  output logic [jcm_pkg::COLOR_W-1:0]         red,
  output logic [jcm_pkg::COLOR_W-1:0]         green,
  output logic [jcm_pkg::COLOR_W-1:0]         blue,
  output logic                                hit,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jcm_pkg::DATA_W-1:0]          cfg_data
);
  import jcm_pkg::*;

  localparam int NMAX   = (MAX_STEPS_PER_SEGMENT < CPS_MAX) ? MAX_STEPS_PER_SEGMENT : CPS_MAX;
  localparam int N_W    = $clog2(NMAX + 1);
  localparam int TOT_W  = $clog2(5 * NMAX + 1);
  localparam int PROD_W = DATA_W + TOT_W;
  localparam int SH_W   = N_W + COLOR_W;

  logic [CPS_W-1:0]         colors_per_segment;
  logic signed [DATA_W-1:0] lower_bound;
  logic signed [DATA_W-1:0] upper_bound;

  logic [N_W-1:0]           n_next;
  logic [TOT_W-1:0]         n_wide;
  logic [N_W-1:0]           n_q;
  logic [TOT_W-1:0]         n2_q;
  logic [TOT_W-1:0]         n3_q;
  logic [TOT_W-1:0]         n4_q;
  logic [TOT_W-1:0]         total_q;
  logic [DATA_W-1:0]        span_q;

  logic                          f_valid;
  tag_t                          f_tag;
  logic [0:0][PROD_W-1:0]        f_prod;
  logic                          d_valid;
  tag_t                          d_tag;
  logic [0:0][TOT_W-1:0]         d_idx;
  logic                          s_valid;
  tag_t                          s_tag;
  logic [1:0][SH_W-1:0]          s_div;
  logic                          r_valid;
  tag_t                          r_tag;
  logic [1:0][COLOR_W-1:0]       r_ramp;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors_per_segment <= CPS_RESET;
      lower_bound        <= LOWER_RESET;
      upper_bound        <= UPPER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLORS: colors_per_segment <= cfg_data[CPS_W-1:0];
        REG_LOWER:  lower_bound        <= cfg_data;
        REG_UPPER:  upper_bound        <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero steps act as one, large counts saturate
  always_comb begin
    if (colors_per_segment == '0) begin
      n_next = N_W'(1);
    end else if (colors_per_segment > CPS_W'(NMAX)) begin
      n_next = N_W'(NMAX);
    end else begin
      n_next = N_W'(colors_per_segment);
    end
    n_wide = TOT_W'(n_next);
  end

  always_ff @(posedge clk) begin
    n_q     <= n_next;
    n2_q    <= n_wide << 1;
    n3_q    <= (n_wide << 1) + n_wide;
    n4_q    <= n_wide << 2;
    total_q <= (n_wide << 2) + n_wide;
    span_q  <= DATA_W'(upper_bound - lower_bound);
  end

  jcm_front #(
    .TOT_W (TOT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .sample    (sample),
    .lower     (lower_bound),
    .upper     (upper_bound),
    .total     (total_q),
    .out_valid (f_valid),
    .out_tag   (f_tag),
    .product   (f_prod[0])
  );

  jcm_div_pipe #(
    .DW    (PROD_W),
    .VW    (DATA_W),
    .QW    (TOT_W),
    .LANES (1)
  ) u_div_idx (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_tag    (f_tag),
    .dividend  (f_prod),
    .divisor   (span_q),
    .out_valid (d_valid),
    .out_tag   (d_tag),
    .quotient  (d_idx)
  );

  jcm_segment #(
    .N_W   (N_W),
    .TOT_W (TOT_W)
  ) u_segment (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_tag    (d_tag),
    .idx       (d_idx[0]),
    .n         (n_q),
    .n2        (n2_q),
    .n3        (n3_q),
    .n4        (n4_q),
    .total     (total_q),
    .out_valid (s_valid),
    .out_tag   (s_tag),
    .dividend  (s_div)
  );

  jcm_div_pipe #(
    .DW    (SH_W),
    .VW    (N_W),
    .QW    (COLOR_W),
    .LANES (2)
  ) u_div_ramp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_tag    (s_tag),
    .dividend  (s_div),
    .divisor   (n_q),
    .out_valid (r_valid),
    .out_tag   (r_tag),
    .quotient  (r_ramp)
  );

  jcm_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_tag    (r_tag),
    .ramp_full (r_ramp[0]),
    .ramp_half (r_ramp[1]),
    .strobe    (strobe),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .hit       (hit)
  );

endmodule

`default_nettype wire

FILE: rtl/jcm_checker.sv
// ----------------------------------------------------------------------------
// jcm_checker
// Port-level checks on beat timing and colour output of the jet colour map.
// ----------------------------------------------------------------------------
`default_nettype none

module jcm_checker #(
  parameter int MAX_STEPS_PER_SEGMENT = 256
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire                                busy,
  input  wire                                strobe,
  input  wire [jcm_pkg::COLOR_W-1:0]         red,
  input  wire [jcm_pkg::COLOR_W-1:0]         green,
  input  wire [jcm_pkg::COLOR_W-1:0]         blue,
  input  wire                                hit,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready
);
  import jcm_pkg::*;

  localparam int NMAX  = (MAX_STEPS_PER_SEGMENT < CPS_MAX) ? MAX_STEPS_PER_SEGMENT : CPS_MAX;
  localparam int TOT_W = $clog2(5 * NMAX + 1);
  localparam int LAT   = 13 + TOT_W;

  // every accepted beat gives exactly one result beat, a fixed time later
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT strobe)
    else $error("accepted sample without result beat");

  a_beat_in: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LAT))
    else $error("result beat without accepted sample");

  a_miss_black: assert property (@(posedge clk) disable iff (rst)
    (strobe && !hit) |-> (red == '0 && green == '0 && blue == '0))
    else $error("out-of-range sample not black");

  // every jet colour has a saturated or at least half-bright channel
  a_hit_bright: assert property (@(posedge clk) disable iff (rst)
    (strobe && hit) |-> (red >= COLOR_HALF || green == COLOR_FULL || blue >= COLOR_HALF))
    else $error("in-range colour off the jet scale");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write held off");

endmodule

bind jet_colormap_lookup jcm_checker #(
  .MAX_STEPS_PER_SEGMENT (MAX_STEPS_PER_SEGMENT)
) u_jcm_checker (.*);

`default_nettype wire
